@@ rtl/modbus_rtu_slave_register_file_macros.svh @@
// Assertion helpers, compiled out for synthesis.
`ifndef MODBUS_RTU_SLAVE_REGISTER_FILE_MACROS_SVH
`define MODBUS_RTU_SLAVE_REGISTER_FILE_MACROS_SVH
`ifndef SYNTHESIS
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/mrs_pkg.sv @@
package mrs_pkg;

  localparam int NUM_REGS_DEF  = 64;
  localparam int MAX_BURST_DEF = 16;

  localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
  localparam logic [7:0]  FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0]  FC_WRITE_MANY = 8'h10;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  ADDR_RESET    = 8'h01;

  typedef enum logic [1:0] {
    CMD_RX  = 2'd0,
    CMD_GAP = 2'd1,
    CMD_WR  = 2'd2,
    CMD_RD  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       start;
    logic       seed;
    logic [7:0] data;
  } crc_req_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_sts_t;

endpackage

@@ rtl/mrs_ram.sv @@
module mrs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mrs_crc.sv @@
module mrs_crc (
  input  logic              clk,
  input  logic              rst_n,
  input  mrs_pkg::crc_req_t req,
  output mrs_pkg::crc_sts_t sts
);
  import mrs_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  // one bit of the reflected CRC per cycle, byte xor folded in at start
  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      crc_nxt  = (req.seed ? CRC_INIT : crc_r) ^ {8'h00, req.data};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      crc_r  <= CRC_INIT;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.crc  = crc_r;

endmodule

@@ rtl/modbus_rtu_slave_register_file.sv @@
// channel | signals                                      | direction
// in      | in_valid/in_ready, cmd rx_byte reg_index reg_data | into block
// out     | out_valid/out_ready, tx_byte tx_last crc_error ... | out of block
// cfg     | psel penable pwrite paddr pwdata prdata pready   | APB slave
//
// A received byte is accepted in S_IDLE, waits in S_RXCRC on the bit-serial
// CRC unit and is judged in S_DECIDE. A reply byte after one that fed the CRC
// unit waits until it is idle; reads add S_TXRD, FC16 words pass S_W16A/B/C.
// After reset a clearing pass (S_CLEAR) zeroes the register file.
// A full output register stalls the sequencer; in_ready is low while busy.
`include "modbus_rtu_slave_register_file_macros.svh"
module modbus_rtu_slave_register_file #(
  parameter int NUM_REGS  = mrs_pkg::NUM_REGS_DEF,
  parameter int MAX_BURST = mrs_pkg::MAX_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic [5:0]  in_reg_index,
  input  logic [15:0] in_reg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_crc_error,
  output logic        out_is_local_read,
  output logic [15:0] out_local_read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrs_pkg::*;

  localparam int FRAME_MAX = 9 + 2 * MAX_BURST;
  localparam int REPLY_MAX = 5 + 2 * MAX_BURST;
  localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int FAW = $clog2(FRAME_MAX);
  localparam int CW  = $clog2(FRAME_MAX + 1);
  localparam int TW  = $clog2(REPLY_MAX + 1);
  localparam int NW  = $clog2(MAX_BURST + 1);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_RXCRC  = 12'b000000000100,
    S_DECIDE = 12'b000000001000,
    S_LRD    = 12'b000000010000,
    S_ERR    = 12'b000000100000,
    S_W16A   = 12'b000001000000,
    S_W16B   = 12'b000010000000,
    S_W16C   = 12'b000100000000,
    S_TXGET  = 12'b001000000000,
    S_TXRD   = 12'b010000000000,
    S_TXOUT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]     addr_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [7:0]     hdr_r [6];
  logic [7:0]     hdr_nxt [6];
  logic [7:0]     last_r, last_nxt, prev_r, prev_nxt;
  logic [15:0]    crc_d1_r, crc_d1_nxt, crc_d2_r, crc_d2_nxt;
  logic [RAW-1:0] clr_r, clr_nxt, rptr_r, rptr_nxt, wptr_r, wptr_nxt;
  logic [FAW-1:0] fptr_r, fptr_nxt;
  logic [NW-1:0]  wcnt_r, wcnt_nxt;
  logic [TW-1:0]  idx_r, idx_nxt, len_r, len_nxt;
  logic [7:0]     hi_r, hi_nxt;
  logic [15:0]    word_r, word_nxt;
  logic           lr_ok_r, lr_ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt, out_err_r, out_err_nxt;
  logic        out_loc_r, out_loc_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic           rf_we;
  logic [RAW-1:0] rf_waddr, rf_raddr;
  logic [15:0]    rf_wdata, rf_rdata;
  logic           fb_we;
  logic [FAW-1:0] fb_waddr;
  logic [7:0]     fb_rdata;

  crc_req_t crc_req;
  crc_sts_t crc_sts;

  logic [15:0] start_w, n_w;
  logic [16:0] end_w, fc16_len_w;
  logic [7:0]  fc_w, tx_sel;
  logic        crc_good, slot_free, serve, tx_last_w;

  mrs_ram #(.W(16), .DEPTH(NUM_REGS), .AW(RAW)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  mrs_ram #(.W(8), .DEPTH(FRAME_MAX), .AW(FAW)) u_frame (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(in_rx_byte),
    .raddr(fptr_r), .rdata(fb_rdata)
  );

  mrs_crc u_crc (.clk(clk), .rst_n(rst_n), .req(crc_req), .sts(crc_sts));

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {24'h0, addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      addr_r <= pwdata[7:0];
    end
  end

  assign start_w    = {hdr_r[2], hdr_r[3]};
  assign n_w        = {hdr_r[4], hdr_r[5]};
  assign fc_w       = hdr_r[1];
  assign end_w      = {1'b0, start_w} + {1'b0, n_w};
  assign fc16_len_w = {n_w, 1'b0} + 17'd9;
  assign crc_good   = (crc_d2_r[7:0] == prev_r) && (crc_d2_r[15:8] == last_r);
  assign slot_free  = !out_valid_r || out_ready;
  assign tx_last_w  = (idx_r == len_r + TW'(1));
  assign in_ready   = (state_r == S_IDLE);
  assign rf_raddr   = (state_r == S_IDLE) ? RAW'(in_reg_index) : rptr_r;
  assign fb_waddr   = count_r[FAW-1:0];

  always_comb begin
    tx_sel = 8'h00;
    if (idx_r == TW'(0)) begin
      tx_sel = addr_r;
    end else if (idx_r == TW'(1)) begin
      tx_sel = fc_w;
    end else if (idx_r == len_r) begin
      tx_sel = crc_sts.crc[7:0];
    end else if (tx_last_w) begin
      tx_sel = crc_sts.crc[15:8];
    end else if (fc_w == FC_READ_HOLD) begin
      if (idx_r == TW'(2)) begin
        tx_sel = {n_w[6:0], 1'b0};
      end else begin
        tx_sel = idx_r[0] ? word_r[15:8] : word_r[7:0];
      end
    end else begin
      case (idx_r)
        TW'(2):  tx_sel = hdr_r[2];
        TW'(3):  tx_sel = hdr_r[3];
        TW'(4):  tx_sel = hdr_r[4];
        TW'(5):  tx_sel = hdr_r[5];
        default: tx_sel = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    hdr_nxt    = hdr_r;
    last_nxt   = last_r;
    prev_nxt   = prev_r;
    crc_d1_nxt = crc_d1_r;
    crc_d2_nxt = crc_d2_r;
    clr_nxt    = clr_r;
    rptr_nxt   = rptr_r;
    wptr_nxt   = wptr_r;
    fptr_nxt   = fptr_r;
    wcnt_nxt   = wcnt_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    hi_nxt     = hi_r;
    word_nxt   = word_r;
    lr_ok_nxt  = lr_ok_r;
    rf_we      = 1'b0;
    rf_waddr   = wptr_r;
    rf_wdata   = 16'h0;
    fb_we      = 1'b0;
    crc_req    = '0;
    serve      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    out_loc_nxt   = out_loc_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_CLEAR: begin
        rf_we    = 1'b1;
        rf_waddr = clr_r;
        clr_nxt  = clr_r + RAW'(1);
        if (clr_r == RAW'(NUM_REGS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_GAP: count_nxt = '0;
            CMD_WR: begin
              if (int'(in_reg_index) < NUM_REGS) begin
                rf_we    = 1'b1;
                rf_waddr = RAW'(in_reg_index);
                rf_wdata = in_reg_data;
              end
            end
            CMD_RD: begin
              rptr_nxt  = RAW'(in_reg_index);
              lr_ok_nxt = int'(in_reg_index) < NUM_REGS;
              state_nxt = S_LRD;
            end
            CMD_RX: begin
              if (int'(count_r) < FRAME_MAX) begin
                fb_we         = 1'b1;
                crc_req.start = 1'b1;
                crc_req.seed  = (count_r == '0);
                crc_req.data  = in_rx_byte;
                crc_d2_nxt    = crc_d1_r;
                crc_d1_nxt    = (count_r == '0) ? CRC_INIT : crc_sts.crc;
                prev_nxt      = last_r;
                last_nxt      = in_rx_byte;
                if (count_r < CW'(6)) begin
                  hdr_nxt[count_r[2:0]] = in_rx_byte;
                end
                count_nxt = count_r + CW'(1);
                state_nxt = S_RXCRC;
              end
            end
            default: ;
          endcase
        end
      end
      S_RXCRC: begin
        if (!crc_sts.busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (count_r >= CW'(2) && hdr_r[0] == addr_r) begin
          if (fc_w == FC_READ_HOLD || fc_w == FC_WRITE_ONE) begin
            if (count_r == CW'(8)) begin
              count_nxt = '0;
              serve     = 1'b1;
            end
          end else if (fc_w == FC_WRITE_MANY) begin
            if (count_r >= CW'(6)) begin
              if (n_w == 16'h0 || int'(n_w) > MAX_BURST) begin
                count_nxt = '0;
              end else if (17'(count_r) == fc16_len_w) begin
                count_nxt = '0;
                serve     = 1'b1;
              end
            end
          end else if (count_r >= CW'(8)) begin
            count_nxt = '0;
          end
        end
        idx_nxt  = '0;
        len_nxt  = TW'(6);
        rptr_nxt = RAW'(start_w);
        wptr_nxt = RAW'(start_w);
        fptr_nxt = FAW'(7);
        wcnt_nxt = NW'(n_w);
        if (serve) begin
          if (!crc_good) begin
            state_nxt = S_ERR;
          end else if (fc_w == FC_READ_HOLD) begin
            len_nxt = TW'(3) + {n_w[TW-2:0], 1'b0};
            if (n_w != 16'h0 && int'(n_w) <= MAX_BURST && int'(end_w) <= NUM_REGS) begin
              state_nxt = S_TXGET;
            end
          end else if (fc_w == FC_WRITE_ONE) begin
            if (int'(start_w) < NUM_REGS) begin
              rf_we     = 1'b1;
              rf_waddr  = RAW'(start_w);
              rf_wdata  = n_w;
              state_nxt = S_TXGET;
            end
          end else begin
            if (int'(end_w) <= NUM_REGS) begin
              state_nxt = S_W16A;
            end
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          out_loc_nxt   = 1'b0;
          out_data_nxt  = 16'h0;
          state_nxt     = S_IDLE;
        end
      end
      S_LRD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b0;
          out_loc_nxt   = 1'b1;
          out_data_nxt  = lr_ok_r ? rf_rdata : 16'h0;
          state_nxt     = S_IDLE;
        end
      end
      S_W16A: begin
        fptr_nxt  = fptr_r + FAW'(1);
        state_nxt = S_W16B;
      end
      S_W16B: begin
        hi_nxt    = fb_rdata;
        fptr_nxt  = fptr_r + FAW'(1);
        state_nxt = S_W16C;
      end
      S_W16C: begin
        rf_we     = 1'b1;
        rf_waddr  = wptr_r;
        rf_wdata  = {hi_r, fb_rdata};
        wptr_nxt  = wptr_r + RAW'(1);
        wcnt_nxt  = wcnt_r - NW'(1);
        state_nxt = (wcnt_r == NW'(1)) ? S_TXGET : S_W16A;
      end
      S_TXGET: begin
        // fetch a register word before its high byte goes out
        if (fc_w == FC_READ_HOLD && idx_r >= TW'(3) && idx_r < len_r && idx_r[0]) begin
          rptr_nxt  = rptr_r + RAW'(1);
          state_nxt = S_TXRD;
        end else begin
          state_nxt = S_TXOUT;
        end
      end
      S_TXRD: begin
        word_nxt  = rf_rdata;
        state_nxt = S_TXOUT;
      end
      S_TXOUT: begin
        if (slot_free && !crc_sts.busy) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = tx_sel;
          out_last_nxt  = tx_last_w;
          out_err_nxt   = 1'b0;
          out_loc_nxt   = 1'b0;
          out_data_nxt  = 16'h0;
          if (idx_r < len_r) begin
            crc_req.start = 1'b1;
            crc_req.seed  = (idx_r == TW'(0));
            crc_req.data  = tx_sel;
          end
          idx_nxt   = idx_r + TW'(1);
          state_nxt = tx_last_w ? S_IDLE : S_TXGET;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    last_r     <= last_nxt;
    prev_r     <= prev_nxt;
    crc_d1_r   <= crc_d1_nxt;
    crc_d2_r   <= crc_d2_nxt;
    rptr_r     <= rptr_nxt;
    wptr_r     <= wptr_nxt;
    fptr_r     <= fptr_nxt;
    wcnt_r     <= wcnt_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    hi_r       <= hi_nxt;
    word_r     <= word_nxt;
    lr_ok_r    <= lr_ok_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    out_loc_r  <= out_loc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_tx_byte         = out_byte_r;
  assign out_tx_last         = out_last_r;
  assign out_crc_error       = out_err_r;
  assign out_is_local_read   = out_loc_r;
  assign out_local_read_data = out_data_r;

  `MRS_ASSERT_IMP(a_crc_no_restart, clk, rst_n, crc_req.start, !crc_sts.busy)
  `MRS_ASSERT_IMP(a_clear_zero, clk, rst_n, state_r == S_CLEAR, rf_we && rf_wdata == 16'h0)
  `MRS_ASSERT_IMP(a_err_frame_reset, clk, rst_n, state_r == S_ERR, count_r == '0)
  `MRS_ASSERT_IMP(a_idx_bound, clk, rst_n, state_r == S_TXOUT, idx_r <= len_r + TW'(1))

endmodule

@@ tb/modbus_rtu_slave_register_file_checker.sv @@
`timescale 1ns / 100ps

module modbus_rtu_slave_register_file_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic [5:0]  in_reg_index,
  input  logic [15:0] in_reg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_tx_last,
  input  logic        out_crc_error,
  input  logic        out_is_local_read,
  input  logic [15:0] out_local_read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          tx_beats,
  output int          crc_errors,
  output int          local_reads
);
  import mrs_pkg::*;

  localparam int NREGS     = NUM_REGS_DEF;
  localparam int BURST     = MAX_BURST_DEF;
  localparam int FRAME_LEN = 9 + 2 * BURST;

  typedef logic [7:0] frame_t [0:FRAME_LEN-1];

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        crc_error;
    logic        is_local;
    logic [15:0] rd_data;
  } reply_beat_t;

  reply_beat_t reply_q[$];
  logic [7:0]  station;
  frame_t      rx_frame;
  int          rx_count;
  logic [15:0] regs [NREGS];

  function automatic logic [15:0] crc16(input frame_t f, input int len);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      c = c ^ {8'h00, f[i]};
      for (int b = 0; b < 8; b++) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
    end
    return c;
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic last, input logic err,
                           input logic lcl, input logic [15:0] d);
    reply_beat_t e;
    e.tx_byte = b;
    e.tx_last = last;
    e.crc_error = err;
    e.is_local = lcl;
    e.rd_data = d;
    reply_q.push_back(e);
  endtask

  task automatic emit_reply(input frame_t msg, input int len);
    logic [15:0] c;
    c = crc16(msg, len);
    msg[len] = c[7:0];
    msg[len+1] = c[15:8];
    for (int i = 0; i < len + 2; i++) push_beat(msg[i], i == len + 1, 1'b0, 1'b0, 16'h0);
  endtask

  task automatic serve_frame(input logic [7:0] fc);
    frame_t      msg;
    logic [31:0] start;
    logic [31:0] n;
    int          crc_at;
    logic [15:0] c;
    start = {rx_frame[2], rx_frame[3]};
    n = {rx_frame[4], rx_frame[5]};
    crc_at = (fc == FC_WRITE_MANY) ? 7 + 2 * int'(n) : 6;
    c = crc16(rx_frame, crc_at);
    if (rx_frame[crc_at] != c[7:0] || rx_frame[crc_at+1] != c[15:8]) begin
      push_beat(8'h00, 1'b1, 1'b1, 1'b0, 16'h0);
      return;
    end
    msg[0] = station;
    msg[1] = fc;
    if (fc == FC_READ_HOLD) begin
      if (n == 0 || n > BURST || start + n > NREGS) return;
      msg[2] = 8'(2 * n);
      for (int i = 0; i < n; i++) begin
        msg[3+2*i] = regs[start+i][15:8];
        msg[4+2*i] = regs[start+i][7:0];
      end
      emit_reply(msg, 3 + 2 * int'(n));
      return;
    end
    if (fc == FC_WRITE_ONE) begin
      if (start >= NREGS) return;
      regs[start] = n[15:0];
    end else begin
      if (start + n > NREGS) return;
      for (int i = 0; i < n; i++) regs[start+i] = {rx_frame[7+2*i], rx_frame[8+2*i]};
    end
    for (int i = 2; i < 6; i++) msg[i] = rx_frame[i];
    emit_reply(msg, 6);
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    logic [7:0]  fc;
    logic [15:0] n;
    if (rx_count >= FRAME_LEN) return;
    rx_frame[rx_count] = b;
    rx_count++;
    if (rx_count < 2 || rx_frame[0] != station) return;
    fc = rx_frame[1];
    if (fc == FC_READ_HOLD || fc == FC_WRITE_ONE) begin
      if (rx_count == 8) begin
        rx_count = 0;
        serve_frame(fc);
      end
    end else if (fc == FC_WRITE_MANY) begin
      if (rx_count >= 6) begin
        n = {rx_frame[4], rx_frame[5]};
        if (n == 0 || n > BURST) rx_count = 0;
        else if (rx_count == 9 + 2 * n) begin
          rx_count = 0;
          serve_frame(fc);
        end
      end
    end else if (rx_count >= 8) begin
      rx_count = 0;
    end
  endtask

  initial begin
    fail_count = 0;
    tx_beats = 0;
    crc_errors = 0;
    local_reads = 0;
  end

  assign pending = reply_q.size();

  always @(posedge clk) begin
    reply_beat_t e;
    if (!rst_n) begin
      station = ADDR_RESET;
      rx_count = 0;
      for (int i = 0; i < NREGS; i++) regs[i] = 16'h0;
      reply_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) station = pwdata[7:0];
      if (out_valid && out_ready) begin
        if (out_crc_error) crc_errors++;
        else if (out_is_local_read) local_reads++;
        else tx_beats++;
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected beat byte=%h last=%b err=%b local=%b data=%h", $time,
                   out_tx_byte, out_tx_last, out_crc_error, out_is_local_read,
                   out_local_read_data);
          fail_count++;
        end else begin
          e = reply_q.pop_front();
          if (e != {out_tx_byte, out_tx_last, out_crc_error, out_is_local_read,
                    out_local_read_data}) begin
            $display("%0t: mismatch expected byte=%h last=%b err=%b local=%b data=%h",
                     $time, e.tx_byte, e.tx_last, e.crc_error, e.is_local, e.rd_data);
            $display("%0t:          actual   byte=%h last=%b err=%b local=%b data=%h",
                     $time, out_tx_byte, out_tx_last, out_crc_error, out_is_local_read,
                     out_local_read_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_GAP: rx_count = 0;
          CMD_WR: regs[in_reg_index] = in_reg_data;
          CMD_RD: push_beat(8'h00, 1'b1, 1'b0, 1'b1, regs[in_reg_index]);
          default: take_rx_byte(in_rx_byte);
        endcase
      end
    end
  end

endmodule

@@ tb/tb_modbus_rtu_slave_register_file.sv @@
`timescale 1ns / 100ps

module tb_modbus_rtu_slave_register_file;
  import mrs_pkg::*;

  typedef logic [7:0] frame_t [0:40];

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [7:0]  in_rx_byte;
  logic [5:0]  in_reg_index;
  logic [15:0] in_reg_data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_tx_byte;
  logic        out_tx_last;
  logic        out_crc_error;
  logic        out_is_local_read;
  logic [15:0] out_local_read_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, tx_beats, crc_errors, local_reads;
  int idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both
  int items_sent;
  logic hold_tgl;
  logic [7:0] cur_station;

  modbus_rtu_slave_register_file u_dut (.*);

  modbus_rtu_slave_register_file_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls per phase, plus a long hold-off on request
  initial begin
    logic seen;
    out_ready = 1'b0;
    seen = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_tgl != seen) begin
        seen = hold_tgl;
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
      end
      if (idle_mode == 2) out_ready <= ($urandom_range(0, 99) >= 62);
      else if (idle_mode == 3) out_ready <= ($urandom_range(0, 99) >= 11);
      else out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [5:0] idx, input logic [15:0] d);
    int pct;
    pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 11 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_rx_byte <= b;
    in_reg_index <= idx;
    in_reg_data <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    // beat taken; drop valid so nothing is offered twice
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_beat(CMD_RX, b, 6'($urandom), 16'($urandom));
  endtask

  task automatic send_gap();
    send_beat(CMD_GAP, 8'($urandom), 6'($urandom), 16'($urandom));
  endtask

  // builds a frame with CRC; an FC16 count field 0 or above the burst limit sends the header only
  task automatic send_frame(input logic [7:0] dst, input logic [7:0] fc,
                            input logic [15:0] start, input logic [15:0] n,
                            input bit good);
    frame_t      f;
    int          len;
    logic [15:0] c;
    f[0] = dst;
    f[1] = fc;
    f[2] = start[15:8];
    f[3] = start[7:0];
    f[4] = n[15:8];
    f[5] = n[7:0];
    if (fc == FC_WRITE_MANY && (n == 0 || n > MAX_BURST_DEF)) begin
      for (int i = 0; i < 6; i++) send_rx(f[i]);
      return;
    end
    len = 6;
    if (fc == FC_WRITE_MANY) begin
      f[6] = 8'(2 * n);
      for (int i = 0; i < 2 * n; i++) f[7+i] = 8'($urandom);
      len = 7 + 2 * n;
    end
    c = u_chk.crc16(f, len);
    f[len] = c[7:0];
    f[len+1] = c[15:8];
    if (!good) f[len + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < len + 2; i++) send_rx(f[i]);
  endtask

  task automatic set_station(input logic [7:0] a);
    wait (pending == 0);
    repeat (60) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {24'($urandom), a};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_station = a;
  endtask

  task automatic random_item();
    int          r;
    logic [15:0] n;
    logic [15:0] st;
    logic [7:0]  fc;
    r = $urandom_range(0, 99);
    if (r < 68) begin
      case ($urandom_range(0, 2))
        0: fc = FC_READ_HOLD;
        1: fc = FC_WRITE_ONE;
        default: fc = FC_WRITE_MANY;
      endcase
      n = ($urandom_range(0, 9) == 0) ? 16'(MAX_BURST_DEF) : 16'($urandom_range(1, 4));
      if (fc == FC_WRITE_ONE) n = 16'($urandom);
      st = (fc == FC_WRITE_ONE) ? 16'($urandom_range(0, 63)) :
           16'($urandom_range(0, 64 - n));
      if ($urandom_range(0, 19) == 0) st = 16'($urandom);
      if ($urandom_range(0, 29) == 0) n = 16'($urandom);
      send_frame(($urandom_range(0, 14) == 0) ? cur_station + 8'd1 : cur_station, fc, st, n,
                 $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) == 0 || n == 0 || n > MAX_BURST_DEF) send_gap();
    end else if (r < 78) begin
      send_beat(CMD_WR, 8'($urandom), 6'($urandom), 16'($urandom));
    end else if (r < 88) begin
      send_beat(CMD_RD, 8'($urandom), 6'($urandom), 16'($urandom));
    end else begin
      repeat ($urandom_range(1, 10)) send_rx(8'($urandom));
      send_gap();
    end
  endtask

  initial begin
    logic [7:0] stations [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_GAP;
    in_rx_byte = 8'h00;
    in_reg_index = 6'd0;
    in_reg_data = 16'h0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'h0;
    idle_mode = 0;
    items_sent = 0;
    hold_tgl = 1'b0;
    cur_station = ADDR_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    set_station(ADDR_RESET);
    send_beat(CMD_WR, 8'hFF, 6'd0, 16'hFFFF);
    send_beat(CMD_WR, 8'h00, 6'd63, 16'hA5A5);
    send_beat(CMD_RD, 8'h00, 6'd0, 16'h0);
    send_beat(CMD_RD, 8'hFF, 6'd63, 16'hFFFF);
    send_frame(cur_station, FC_READ_HOLD, 16'd0, 16'd1, 1);
    send_frame(cur_station, FC_READ_HOLD, 16'd48, 16'd16, 1);
    send_frame(cur_station, FC_READ_HOLD, 16'd0, 16'd0, 1);      // zero count
    send_frame(cur_station, FC_READ_HOLD, 16'd0, 16'd17, 1);     // above burst
    send_frame(cur_station, FC_READ_HOLD, 16'd60, 16'd5, 1);     // past the end
    send_frame(cur_station, FC_WRITE_ONE, 16'd63, 16'hFFFF, 1);
    send_frame(cur_station, FC_WRITE_ONE, 16'd64, 16'h1234, 1);  // past the end
    send_frame(cur_station, FC_WRITE_MANY, 16'd0, 16'd1, 1);
    send_frame(cur_station, FC_WRITE_MANY, 16'd48, 16'd16, 1);
    send_frame(cur_station, FC_WRITE_MANY, 16'd60, 16'd5, 1);    // past the end
    send_frame(cur_station, FC_WRITE_MANY, 16'd0, 16'd0, 1);
    send_gap();
    send_frame(cur_station, FC_WRITE_MANY, 16'd0, 16'd17, 1);
    send_gap();
    send_frame(cur_station, FC_READ_HOLD, 16'd0, 16'd2, 0);      // bad CRC
    send_frame(cur_station, 8'h07, 16'd0, 16'd1, 1);             // unknown code
    send_frame(cur_station + 8'd1, FC_READ_HOLD, 16'd0, 16'd1, 1);
    send_gap();
    repeat (45) send_rx(8'hFF);                                   // overflow
    send_gap();
    send_frame(cur_station, FC_READ_HOLD, 16'd0, 16'd16, 1);

    // random phases
    stations[0] = 8'd247;
    stations[1] = 8'($urandom_range(2, 246));
    stations[2] = ADDR_RESET;
    stations[3] = 8'd1;
    for (int ph = 0; ph < 4; ph++) begin
      int goal;
      set_station(stations[ph]);
      idle_mode = ph;
      goal = items_sent + 64;
      if (ph == 2) begin
        send_frame(cur_station, FC_READ_HOLD, 16'd0, 16'd16, 1);
        hold_tgl <= ~hold_tgl;
        repeat (4) send_frame(cur_station, FC_READ_HOLD, 16'd16, 16'd16, 1);
      end
      while (items_sent < goal) random_item();
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (500) @(negedge clk);
    $display("Covered %0d input beats over four stall mixes and stations 1, 247 and one between.",
             items_sent);
    $display("Reply bytes %0d, CRC errors %0d, local reads %0d.", tx_beats, crc_errors,
             local_reads);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
